FILE: design/c2rp_pkg.sv
// shared types and constants of the replicate-padded 2-d filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package c2rp_pkg;

  // field widths of the beats
  localparam int unsigned OUT_W     = 40;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned COL_OUT_W = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned PIX_IN_W  = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  // input opcodes
  localparam logic [OP_W-1:0] OP_TAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD  = 2'd2;

  // results allowed per input beat
  localparam logic [1:0] RUN_PIXEL = 2'd3;
  localparam logic [1:0] RUN_DRAIN = 2'd1;

  // control from the sequencer into the multiply-accumulate pipe
  typedef struct packed {
    logic clr;
    logic issue;
    logic last;
  } mac_ctl_t;

endpackage
`default_nettype wire

FILE: design/c2rp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module c2rp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/c2rp_mac.sv
// shared multiply-accumulate pipe: ram data, product register, accumulator
// depends on c2rp_pkg
`timescale 1ns / 1ps
`default_nettype none
module c2rp_mac
  import c2rp_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctl_t                ctl_i,
  input  logic [PIXEL_BITS-1:0]   pix_i,
  input  logic [COEF_W-1:0]       tap_i,
  output logic signed [OUT_W-1:0] acc_o,
  output logic                    done_o
);

  localparam int unsigned PW = PIXEL_BITS + COEF_W;

  logic                 v1_q, l1_q, v2_q, l2_q, done_q;
  logic signed [PW-1:0] prod_q;
  logic signed [OUT_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= ctl_i.issue;
      l1_q   <= ctl_i.issue & ctl_i.last;
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      done_q <= v2_q & l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(pix_i) * $signed(tap_i);
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + OUT_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: design/conv2d_replicate_pad.sv
// channel  | handshake                 | payload
// in       | in_valid_i / in_stall_o   | op_i, coef_index_i, coef_value_i, pixel_value_i
// out      | out_valid_o / out_stall_i | out_value_o, out_row_o, out_col_o, last_in_run_o,
//          |                           | frame_end_o
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a tap write leaves the sequencer idle; a pixel or drain beat starts it, and it builds
// each result with the single multiply-accumulate walking the window
// through one line store read port, and goes back to idle when no result is ready.
// a pixel beat gives up to three results, a drain one. each result also waits while the
// output register is full and stalled; the input stalls until the beat's results are
// queued. reset clears counters, registers and control only;
// line store and taps hold garbage until written.
// depends on c2rp_pkg, c2rp_ram, c2rp_mac
`timescale 1ns / 1ps
`default_nettype none
module conv2d_replicate_pad
  import c2rp_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_PAD    = 2,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [IDX_W-1:0]        coef_index_i,
  input  logic signed [COEF_W-1:0] coef_value_i,
  input  logic signed [PIX_IN_W-1:0] pixel_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] out_value_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [COL_OUT_W-1:0]    out_col_o,
  output logic                    last_in_run_o,
  output logic                    frame_end_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int unsigned SR       = 2 * MAX_PAD + 1;
  localparam int unsigned NUM_TAPS = SR * SR;
  localparam int unsigned CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RMW      = (SR > 1) ? $clog2(SR) : 1;
  localparam int unsigned LDEPTH   = SR * MAX_COLS;
  localparam int unsigned AW       = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int unsigned TAW      = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int unsigned VCW      = CW + 4;
  localparam int unsigned VRW      = 12;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_WIN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // ---------------------------------------------------------------- registers
  logic [2:0]  state_q, state_d;
  logic [10:0] cfg_rows_q;
  logic [8:0]  cfg_cols_q;
  logic [1:0]  cfg_pad_q;

  logic [ROW_W-1:0] in_r_q, in_r_d, out_r_q, out_r_d;
  logic [CW-1:0]    in_c_q, in_c_d, out_c_q, out_c_d;
  logic [RMW-1:0]   in_m_q, in_m_d, out_m_q, out_m_d;
  logic             done_q, done_d;

  logic [1:0] run_q, run_d, lim_q, lim_d;

  logic signed [VRW-1:0] vr_q, vr_d;
  logic signed [VCW-1:0] vc_q, vc_d, vc0_q, vc0_d;
  logic [RMW-1:0]        wm_q, wm_d;
  logic [2:0]            k1_q, k1_d, k2_q, k2_d;
  logic [TAW-1:0]        tap_q, tap_d;

  logic                    ov_q, ov_d;
  logic signed [OUT_W-1:0] oval_q, oval_d;
  logic [ROW_W-1:0]        orow_q, orow_d;
  logic [COL_OUT_W-1:0]    ocol_q, ocol_d;
  logic                    olast_q, olast_d, oend_q, oend_d;

  // ---------------------------------------------------------------- effective registers
  logic [ROW_W-1:0] rmax;
  logic [CW-1:0]    cmax;
  logic [1:0]       pad;

  always_comb begin
    if (cfg_rows_q == 11'd0) begin
      rmax = '0;
    end else if (cfg_rows_q > 11'd1024) begin
      rmax = 10'd1023;
    end else begin
      rmax = 10'(cfg_rows_q - 11'd1);
    end
    if (cfg_cols_q == 9'd0) begin
      cmax = '0;
    end else if (32'(cfg_cols_q) > MAX_COLS) begin
      cmax = CW'(MAX_COLS - 1);
    end else begin
      cmax = CW'(cfg_cols_q - 9'd1);
    end
    if (32'(cfg_pad_q) > MAX_PAD) begin
      pad = 2'(MAX_PAD);
    end else begin
      pad = cfg_pad_q;
    end
  end

  // an output is ready once its clamped bottom-right neighbour has arrived
  function automatic logic out_ready(input logic [ROW_W-1:0] orr, input logic [CW-1:0] occ,
                                     input logic [ROW_W-1:0] irr, input logic [CW-1:0] icc,
                                     input logic dn, input logic [1:0] p,
                                     input logic [ROW_W-1:0] rm, input logic [CW-1:0] cm);
    logic [ROW_W:0] nr;
    logic [CW:0]    nc;
    nr = {1'b0, orr} + (ROW_W+1)'(p);
    if (nr > {1'b0, rm}) nr = {1'b0, rm};
    nc = {1'b0, occ} + (CW+1)'(p);
    if (nc > {1'b0, cm}) nc = {1'b0, cm};
    return dn || (nr < {1'b0, irr}) || ((nr == {1'b0, irr}) && (nc < {1'b0, icc}));
  endfunction

  // ---------------------------------------------------------------- stores
  logic                  in_acc, cfg_we;
  logic                  line_we, tap_we;
  logic [AW-1:0]         line_waddr, line_raddr;
  logic [PIXEL_BITS-1:0] line_rdata;
  logic [COEF_W-1:0]     tap_rdata;
  logic [CW-1:0]         cc;
  mac_ctl_t              mac_ctl;
  logic signed [OUT_W-1:0] acc;
  logic                  mac_done;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign line_we    = in_acc && (op_i == OP_PIXEL) && !done_q;
  assign tap_we     = in_acc && (op_i == OP_TAP) && (32'(coef_index_i) < NUM_TAPS);
  assign line_waddr = AW'(in_m_q) * AW'(MAX_COLS) + AW'(in_c_q);

  // replicate padding on columns: clamp the virtual column
  always_comb begin
    if (vc_q[VCW-1]) begin
      cc = '0;
    end else if (vc_q[VCW-2:0] > (VCW-1)'(cmax)) begin
      cc = cmax;
    end else begin
      cc = vc_q[CW-1:0];
    end
  end
  assign line_raddr = AW'(wm_q) * AW'(MAX_COLS) + AW'(cc);

  c2rp_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LDEPTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (PIXEL_BITS'($unsigned(pixel_value_i))),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  c2rp_ram #(.WIDTH(COEF_W), .DEPTH(NUM_TAPS)) u_taps (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (TAW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (tap_q),
    .rdata_o (tap_rdata)
  );

  c2rp_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .pix_i  (line_rdata),
    .tap_i  (tap_rdata),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // ---------------------------------------------------------------- sequencer
  logic [ROW_W-1:0] nx_r;
  logic [CW-1:0]    nx_c;
  logic [RMW-1:0]   nx_m;
  logic             nx_done, frame_last, win_last;
  logic [1:0]       a_r;
  logic signed [VRW-1:0] vr_nx;

  always_comb begin
    state_d = state_q;
    in_r_d = in_r_q; in_c_d = in_c_q; in_m_d = in_m_q; done_d = done_q;
    out_r_d = out_r_q; out_c_d = out_c_q; out_m_d = out_m_q;
    run_d = run_q; lim_d = lim_q;
    vr_d = vr_q; vc_d = vc_q; vc0_d = vc0_q; wm_d = wm_q;
    k1_d = k1_q; k2_d = k2_q; tap_d = tap_q;
    ov_d = ov_q; oval_d = oval_q; orow_d = orow_q; ocol_d = ocol_q;
    olast_d = olast_q; oend_d = oend_q;
    mac_ctl = '0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    // counters after emitting the current output
    frame_last = (out_r_q == rmax) && (out_c_q == cmax);
    nx_r = out_r_q; nx_c = out_c_q; nx_m = out_m_q; nx_done = done_q;
    if (frame_last) begin
      nx_r = '0; nx_c = '0; nx_m = '0; nx_done = 1'b0;
    end else if (out_c_q == cmax) begin
      nx_c = '0;
      nx_r = out_r_q + 10'd1;
      nx_m = (32'(out_m_q) == SR - 1) ? '0 : out_m_q + RMW'(1);
    end else begin
      nx_c = out_c_q + CW'(1);
    end

    a_r = (out_r_q < {8'b0, pad}) ? out_r_q[1:0] : pad;
    win_last = (k1_q == {pad, 1'b0}) && (k2_q == {pad, 1'b0});
    vr_nx = vr_q + VRW'(1);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((op_i == OP_PIXEL) && !done_q) begin
            if (in_c_q == cmax) begin
              in_c_d = '0;
              if (in_r_q == rmax) begin
                in_r_d = '0;
                in_m_d = '0;
                done_d = 1'b1;
              end else begin
                in_r_d = in_r_q + 10'd1;
                in_m_d = (32'(in_m_q) == SR - 1) ? '0 : in_m_q + RMW'(1);
              end
            end else begin
              in_c_d = in_c_q + CW'(1);
            end
            run_d   = '0;
            lim_d   = RUN_PIXEL;
            state_d = S_CHK;
          end else if (op_i == OP_DRAIN) begin
            run_d   = '0;
            lim_d   = RUN_DRAIN;
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (out_ready(out_r_q, out_c_q, in_r_q, in_c_q, done_q, pad, rmax, cmax)) begin
          // window starts at the clamped top-left neighbour
          vr_d  = VRW'(out_r_q) - VRW'(pad);
          vc_d  = VCW'(out_c_q) - VCW'(pad);
          vc0_d = VCW'(out_c_q) - VCW'(pad);
          wm_d  = (out_m_q >= RMW'(a_r)) ? out_m_q - RMW'(a_r)
                : RMW'({1'b0, out_m_q} + (RMW+1)'(SR) - (RMW+1)'(a_r));
          k1_d  = '0;
          k2_d  = '0;
          tap_d = '0;
          mac_ctl.clr = 1'b1;
          state_d = S_WIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WIN: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.last  = win_last;
        tap_d = tap_q + TAW'(1);
        if (k2_q == {pad, 1'b0}) begin
          k2_d = '0;
          k1_d = k1_q + 3'd1;
          vc_d = vc0_q;
          vr_d = vr_nx;
          if ((vr_nx > 0) && (vr_nx <= $signed(VRW'(rmax)))) begin
            wm_d = (32'(wm_q) == SR - 1) ? '0 : wm_q + RMW'(1);
          end
        end else begin
          k2_d = k2_q + 3'd1;
          vc_d = vc_q + VCW'(1);
        end
        if (win_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          oval_d  = acc;
          orow_d  = out_r_q;
          ocol_d  = COL_OUT_W'(out_c_q);
          oend_d  = frame_last;
          olast_d = (run_q + 2'd1 == lim_q) ||
                    !out_ready(nx_r, nx_c, frame_last ? '0 : in_r_q,
                               frame_last ? '0 : in_c_q, nx_done, pad, rmax, cmax);
          out_r_d = nx_r;
          out_c_d = nx_c;
          out_m_d = nx_m;
          done_d  = nx_done;
          if (frame_last) begin
            in_r_d = '0;
            in_c_d = '0;
            in_m_d = '0;
          end
          run_d   = run_q + 2'd1;
          state_d = olast_d ? S_IDLE : S_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // any register write restarts the frame
    if (cfg_we) begin
      in_r_d = '0; in_c_d = '0; in_m_d = '0;
      out_r_d = '0; out_c_d = '0; out_m_d = '0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_rows_q <= 11'd144;
      cfg_cols_q <= 9'd176;
      cfg_pad_q  <= 2'd1;
      in_r_q     <= '0;
      in_c_q     <= '0;
      in_m_q     <= '0;
      done_q     <= 1'b0;
      out_r_q    <= '0;
      out_c_q    <= '0;
      out_m_q    <= '0;
      run_q      <= '0;
      lim_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (cfg_index_i)
          REG_ROWS: cfg_rows_q <= cfg_data_i;
          REG_COLS: cfg_cols_q <= cfg_data_i[8:0];
          REG_PAD:  cfg_pad_q  <= cfg_data_i[1:0];
          default:  ;
        endcase
      end
      in_r_q  <= in_r_d;
      in_c_q  <= in_c_d;
      in_m_q  <= in_m_d;
      done_q  <= done_d;
      out_r_q <= out_r_d;
      out_c_q <= out_c_d;
      out_m_q <= out_m_d;
      run_q   <= run_d;
      lim_q   <= lim_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vr_q    <= vr_d;
    vc_q    <= vc_d;
    vc0_q   <= vc0_d;
    wm_q    <= wm_d;
    k1_q    <= k1_d;
    k2_q    <= k2_d;
    tap_q   <= tap_d;
    oval_q  <= oval_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
    oend_q  <= oend_d;
  end

  assign out_valid_o   = ov_q;
  assign out_value_o   = oval_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign last_in_run_o = olast_q;
  assign frame_end_o   = oend_q;

endmodule
`default_nettype wire

FILE: dv/conv2d_replicate_pad_check.sv
// checker for the replicate-padded 2-d filter: watches the in, out and cfg channels,
// predicts every filtered pixel and compares it with the out beats. depends on c2rp_pkg
`timescale 1ns / 1ps
module conv2d_replicate_pad_check
  import c2rp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [OP_W-1:0]            op_i,
  input  logic [IDX_W-1:0]           coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic signed [PIX_IN_W-1:0] pixel_value_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [OUT_W-1:0]    out_value_i,
  input  logic [ROW_W-1:0]           out_row_i,
  input  logic [COL_OUT_W-1:0]       out_col_i,
  input  logic                       last_in_run_i,
  input  logic                       frame_end_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         result_count_o,
  output logic                       flushing_o
);

  localparam int STORE_ROWS = 5;
  localparam int LINE_W     = 256;
  localparam int NUM_TAPS   = 25;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_OUT_W-1:0]    col;
    logic                    last;
    logic                    fend;
  } filt_pix_t;

  filt_pix_t          filt_q[$];
  logic signed [15:0] rows_buf [STORE_ROWS][LINE_W];
  logic signed [15:0] coef_m [NUM_TAPS];
  int unsigned        reg_rows, reg_cols, reg_pad;
  int unsigned        in_r, in_c, out_r, out_c;
  bit                 frame_full;
  int                 fails, results;

  function automatic int unsigned rows_used();
    if (reg_rows < 1) return 1;
    if (reg_rows > 1024) return 1024;
    return reg_rows;
  endfunction

  function automatic int unsigned cols_used();
    if (reg_cols < 1) return 1;
    if (reg_cols > LINE_W) return LINE_W;
    return reg_cols;
  endfunction

  function automatic int unsigned pad_used();
    return (reg_pad > 2) ? 2 : reg_pad;
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic bit window_full();
    int unsigned nr, nc;
    nr = out_r + pad_used();
    nc = out_c + pad_used();
    if (frame_full) return 1;
    if (nr > rows_used() - 1) nr = rows_used() - 1;
    if (nc > cols_used() - 1) nc = cols_used() - 1;
    if (nr < in_r) return 1;
    return (nr == in_r) && (nc < in_c);
  endfunction

  function automatic void restart_frame();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    frame_full = 0;
  endfunction

  task automatic filter_one(output filt_pix_t res);
    int     p, side, rr, cc;
    longint acc;
    p    = pad_used();
    side = 2 * p + 1;
    acc  = 0;
    for (int k1 = -p; k1 <= p; k1++) begin
      for (int k2 = -p; k2 <= p; k2++) begin
        rr = clamp_to(int'(out_r) + k1, int'(rows_used()) - 1);
        cc = clamp_to(int'(out_c) + k2, int'(cols_used()) - 1);
        acc += longint'(rows_buf[rr % STORE_ROWS][cc]) *
               longint'(coef_m[(k1 + p) * side + (k2 + p)]);
      end
    end
    res.value = acc[OUT_W-1:0];
    res.row   = out_r[ROW_W-1:0];
    res.col   = out_c[COL_OUT_W-1:0];
    res.last  = 0;
    res.fend  = (out_r == rows_used() - 1) && (out_c == cols_used() - 1);
    if (res.fend) begin
      restart_frame();
    end else if (++out_c >= cols_used()) begin
      out_c = 0;
      out_r++;
    end
  endtask

  // the last result of a run carries last_in_run
  task automatic filter_run(input int limit);
    filt_pix_t held, nxt;
    bit        have;
    int        n;
    have = 0;
    n    = 0;
    while (n < limit && window_full()) begin
      filter_one(nxt);
      if (have) filt_q.push_back(held);
      held = nxt;
      have = 1;
      n++;
    end
    if (have) begin
      held.last = 1;
      filt_q.push_back(held);
    end
  endtask

  task automatic take_beat();
    case (op_i)
      OP_TAP: begin
        if (coef_index_i < NUM_TAPS) coef_m[coef_index_i] = coef_value_i;
      end
      OP_PIXEL: begin
        if (!frame_full) begin
          rows_buf[in_r % STORE_ROWS][in_c] = pixel_value_i;
          if (++in_c >= cols_used()) begin
            in_c = 0;
            if (++in_r >= rows_used()) begin
              in_r       = 0;
              frame_full = 1;
            end
          end
          filter_run(3);
        end
      end
      OP_DRAIN: filter_run(1);
      default: ;
    endcase
  endtask

  task automatic check_beat();
    filt_pix_t w;
    results++;
    if (filt_q.size() == 0) begin
      $display("%0t: unexpected out beat value %0d row %0d col %0d", $time,
               out_value_i, out_row_i, out_col_i);
      fails++;
    end else begin
      w = filt_q.pop_front();
      if (out_value_i !== w.value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, w.value, out_value_i);
        fails++;
      end
      if (out_row_i !== w.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, w.row, out_row_i);
        fails++;
      end
      if (out_col_i !== w.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, w.col, out_col_i);
        fails++;
      end
      if (last_in_run_i !== w.last) begin
        $display("%0t: last_in_run expected %0d actual %0d", $time, w.last, last_in_run_i);
        fails++;
      end
      if (frame_end_i !== w.fend) begin
        $display("%0t: frame_end expected %0d actual %0d", $time, w.fend, frame_end_i);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_rows = 144;
      reg_cols = 176;
      reg_pad  = 1;
      restart_frame();
      filt_q.delete();
      fails   = 0;
      results = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROWS: reg_rows = cfg_data_i;
          REG_COLS: reg_cols = cfg_data_i[8:0];
          REG_PAD:  reg_pad  = cfg_data_i[1:0];
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid_i && !in_stall_i) take_beat();
    end
    fail_count_o   <= fails;
    pending_o      <= filt_q.size();
    result_count_o <= results;
    flushing_o     <= frame_full;
  end

endmodule

FILE: dv/conv2d_replicate_pad_test.sv
// top of the filter testbench: clock, reset, register writes and beat stimulus with
// random idling; depends on c2rp_pkg, conv2d_replicate_pad and conv2d_replicate_pad_check
`timescale 1ns / 1ps
module conv2d_replicate_pad_test;
  import c2rp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
  localparam int                   LIMIT     = 1500000;
  localparam int                   SETTLE    = 150;
  localparam int                   CUT_MAX   = 40;

  logic                       clk_i = 0;
  logic                       rst_ni = 0;
  logic                       in_valid = 0;
  logic                       in_stall_o;
  logic [OP_W-1:0]            op = '0;
  logic [IDX_W-1:0]           coef_index = '0;
  logic signed [COEF_W-1:0]   coef_value = '0;
  logic signed [PIX_IN_W-1:0] pixel_value = '0;
  logic                       out_valid_o;
  logic                       out_stall = 0;
  logic signed [OUT_W-1:0]    out_value_o;
  logic [ROW_W-1:0]           out_row_o;
  logic [COL_OUT_W-1:0]       out_col_o;
  logic                       last_in_run_o, frame_end_o;
  logic                       cfg_valid = 0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DAT_W-1:0]       cfg_data = '0;
  int                         fail_count, pending, result_count;
  logic                       flushing;

  bit calm = 0;
  int beats_sent = 0, frames_run = 0, cycles = 0, stall_left = 0;

  conv2d_replicate_pad uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .op_i(op), .coef_index_i(coef_index), .coef_value_i(coef_value),
    .pixel_value_i(pixel_value),
    .out_valid_o, .out_stall_i(out_stall),
    .out_value_o, .out_row_o, .out_col_o, .last_in_run_o, .frame_end_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  conv2d_replicate_pad_check chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall_o),
    .op_i(op), .coef_index_i(coef_index), .coef_value_i(coef_value),
    .pixel_value_i(pixel_value),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall),
    .out_value_i(out_value_o), .out_row_i(out_row_o), .out_col_i(out_col_o),
    .last_in_run_i(last_in_run_o), .frame_end_i(frame_end_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .flushing_o(flushing)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] cv, input logic [PIX_IN_W-1:0] pv);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1;
    op          <= o;
    coef_index  <= idx;
    coef_value  <= cv;
    pixel_value <= pv;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  task automatic send_pixel(input logic [PIX_IN_W-1:0] pv);
    send_beat(OP_PIXEL, IDX_W'($urandom), COEF_W'($urandom), pv);
  endtask

  task automatic send_tap(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] cv);
    send_beat(OP_TAP, idx, cv, PIX_IN_W'($urandom));
  endtask

  // sender holds off until every due result has come and the pipe is empty
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    @(negedge clk_i);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  task automatic load_taps(input bit extremes);
    for (int t = 0; t < 25; t++) begin
      if (extremes && t == 0) send_tap(IDX_W'(t), 16'sh8000);
      else if (extremes && t == 4) send_tap(IDX_W'(t), 16'sh7fff);
      else send_tap(IDX_W'(t), COEF_W'($urandom));
    end
  endtask

  task automatic noise_beat();
    case ($urandom_range(0, 2))
      0: send_beat(OP_SPARE, IDX_W'($urandom), COEF_W'($urandom), PIX_IN_W'($urandom));
      1: send_tap(IDX_W'($urandom), COEF_W'($urandom));
      default: send_beat(OP_DRAIN, IDX_W'($urandom), COEF_W'($urandom),
                         PIX_IN_W'($urandom));
    endcase
  endtask

  // one image; a cut frame stops early and is restarted by the next register write
  task automatic run_frame(input logic [CFG_DAT_W-1:0] rows, input logic [CFG_DAT_W-1:0] cols,
                           input logic [CFG_DAT_W-1:0] pad, input bit cut, input bit spikes);
    int r_eff, c_eff, total, stop;
    logic [PIX_IN_W-1:0] pv;
    settle();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_PAD, pad);
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, CFG_DAT_W'($urandom));
    r_eff = (rows < 1) ? 1 : (rows > 1024) ? 1024 : rows;
    c_eff = (cols[8:0] < 1) ? 1 : (cols[8:0] > 256) ? 256 : cols[8:0];
    total = r_eff * c_eff;
    stop  = cut ? $urandom_range(1, (total < CUT_MAX) ? total : CUT_MAX) : total;
    frames_run++;
    // drain with nothing ready at the start of the image
    if ($urandom_range(0, 3) == 0) send_beat(OP_DRAIN, '0, '0, '0);
    for (int i = 0; i < stop; i++) begin
      if (!calm && $urandom_range(0, 11) == 0) noise_beat();
      pv = PIX_IN_W'($urandom);
      if (spikes) begin
        case (i % 5)
          0: pv = 16'sh7fff;
          1: pv = 16'sh8000;
          2: pv = '0;
          3: pv = '1;
          default: ;
        endcase
      end
      send_pixel(pv);
    end
    if (cut) return;
    forever begin
      #1;
      if (!flushing) break;
      // a pixel while the frame drains is dropped
      if ($urandom_range(0, 7) == 0) send_pixel(PIX_IN_W'($urandom));
      else send_beat(OP_DRAIN, IDX_W'($urandom), COEF_W'($urandom), PIX_IN_W'($urandom));
    end
  endtask

  initial begin
    int stop_at;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: taps with extremes, ignored taps and op, two small frames of extreme pixels
    load_taps(1);
    send_tap(5'd25, 16'sh1234);
    send_tap(5'd31, 16'sh7fff);
    send_beat(OP_SPARE, '1, '1, '1);
    run_frame(11'd3, 11'd4, 11'd1, 0, 1);
    run_frame(11'd2, 11'd3, 11'd2, 0, 1);

    // random small frames with the odd cut frame and tap reload
    stop_at = beats_sent + 250;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) load_taps(0);
      run_frame(CFG_DAT_W'($urandom_range(0, 7)), CFG_DAT_W'($urandom_range(0, 12)),
                CFG_DAT_W'($urandom_range(0, 3)), $urandom_range(0, 7) == 0, 0);
    end

    // register extremes, each image cut short: tallest, widest, a couple of odd sizes
    run_frame(11'h7ff, 11'd0, 11'd0, 1, 0);
    run_frame(11'd0, 11'd300, 11'd2, 1, 0);
    run_frame(11'd1024, 11'd1, 11'd2, 1, 0);
    run_frame(11'd2, 11'd256, 11'd3, 1, 1);

    // last part with no idling on either side
    calm = 1;
    for (int k = 0; k < 3; k++)
      run_frame(CFG_DAT_W'($urandom_range(1, 6)), CFG_DAT_W'($urandom_range(1, 10)),
                CFG_DAT_W'($urandom_range(0, 2)), 0, 0);

    settle();
    $display("%0d input beats over %0d frames, %0d filtered pixels checked",
             beats_sent, frames_run, result_count);
    $display("pad sizes 0 to 3, small full images and cut images up to 1024 rows and 256 columns");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: conv2d_replicate_pad.f
design/c2rp_pkg.sv
design/c2rp_ram.sv
design/c2rp_mac.sv
design/conv2d_replicate_pad.sv
dv/conv2d_replicate_pad_check.sv
dv/conv2d_replicate_pad_test.sv
